/* hw/rtl/epd_pkg.sv */
// ----------------------------------------------------------------------------
// Endless potentiometer decoder package
// Shared widths, constants and the control word of the arithmetic unit.
// ----------------------------------------------------------------------------
package epd_pkg;

  localparam int VAL_W           = 10;
  localparam int DEF_NUM_SAMPLES = 8;
  // Fraction bits of the reciprocal of the ring length. Twenty-two bits keep
  // the quotient exact for every sum of up to 64 ring entries.
  localparam int DIV_SHIFT       = 22;

  localparam logic [VAL_W-1:0] HYST_RESET = 10'd2;
  localparam logic [VAL_W-1:0] POS_HALF   = 10'd512;
  localparam logic [VAL_W:0]   POS_FULL   = 11'd1024;

  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  typedef enum logic [1:0] {
    UOP_NOP = 2'd0,
    UOP_CLR = 2'd1,
    UOP_ACC = 2'd2,
    UOP_DIV = 2'd3
  } unit_op_t;

  typedef struct packed {
    unit_op_t            op;
  } unit_ctrl_t;

endpackage

/* hw/rtl/endless_pot_position_decoder_core.sv */
// ----------------------------------------------------------------------------
// Endless potentiometer position decoder
// Filters wiper pairs by hysteresis, averages two sample rings and derives
// the angular position and the direction of rotation.
// ----------------------------------------------------------------------------
// One word is taken at a time. A pair that fails the hysteresis test goes from
// the check state straight to the finish state and presents its result as the
// block becomes ready again. An accepted pair passes through the write, sum,
// drain, divide and update states before the finish state, and the next word
// is taken only once its result is registered: the ring RAM is read one
// entry per cycle into a single accumulator pair, and the two averages then
// come from a multiplication of each sum by the reciprocal of the ring length
// on the same unit. Ring entries not yet written read as zero, so no clearing
// pass follows reset. A result that is not taken holds the block in its finish
// state until the result register is free.
module endless_pot_position_decoder_core
  import epd_pkg::*;
#(
  parameter int NUM_SAMPLES = DEF_NUM_SAMPLES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data,   // hysteresis
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [9:0] wiper_a, [19:10] wiper_b, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [9:0] position, [10] direction, rest zero
  output logic        out_tuser   // [0] accepted
);

  localparam int AW = (NUM_SAMPLES > 1) ? $clog2(NUM_SAMPLES) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(NUM_SAMPLES - 1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_WRITE = 8'b0000_0100,
    S_SUM   = 8'b0000_1000,
    S_DRAIN = 8'b0001_0000,
    S_DIV   = 8'b0010_0000,
    S_UPD   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [VAL_W-1:0]  hyst_r;
  logic [VAL_W-1:0]  a_r, b_r;
  logic [AW-1:0]     slot_r;
  logic              full_r;
  logic [AW-1:0]     rd_cnt_r;
  logic              rd_pend_r;
  logic              rd_mask_r;
  logic [VAL_W-1:0]  prev_a_r, prev_b_r;
  logic [VAL_W-1:0]  angle_r;
  logic              dir_r;
  logic              ok_r;
  logic              out_valid_r;
  logic [VAL_W-1:0]  out_pos_r;
  logic              out_dir_r;
  logic              out_acc_r;

  logic [VAL_W-1:0]   diff_a, diff_b;
  logic               ok;
  logic               out_free;
  logic [2*VAL_W-1:0] ram_rdata;
  logic [VAL_W-1:0]   unit_in_a, unit_in_b;
  logic [VAL_W-1:0]   avg_a, avg_b;
  unit_ctrl_t         uctrl;
  logic [VAL_W:0]     up_diff;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  assign diff_a = (a_r >= prev_a_r) ? (a_r - prev_a_r) : (prev_a_r - a_r);
  assign diff_b = (b_r >= prev_b_r) ? (b_r - prev_b_r) : (prev_b_r - b_r);
  assign ok     = (diff_a >= hyst_r) && (diff_b >= hyst_r);

  epd_ram #(
    .WIDTH (2 * VAL_W),
    .DEPTH (NUM_SAMPLES)
  ) u_ring (
    .clk     (clk),
    .wr_en   (state_r == S_WRITE),
    .wr_addr (slot_r),
    .wr_data ({b_r, a_r}),
    .rd_addr (rd_cnt_r),
    .rd_data (ram_rdata)
  );

  // Slots are filled in order, so a slot is written once the ring has wrapped
  // or the slot lies below the write pointer.
  assign unit_in_a = rd_mask_r ? ram_rdata[VAL_W-1:0]       : '0;
  assign unit_in_b = rd_mask_r ? ram_rdata[2*VAL_W-1:VAL_W] : '0;

  always_comb begin
    uctrl.op = UOP_NOP;
    case (state_r)
      S_CHECK: uctrl.op = UOP_CLR;
      S_SUM:   uctrl.op = rd_pend_r ? UOP_ACC : UOP_NOP;
      S_DRAIN: uctrl.op = UOP_ACC;
      S_DIV:   uctrl.op = UOP_DIV;
      default: uctrl.op = UOP_NOP;
    endcase
  end

  epd_unit #(
    .NUM_SAMPLES (NUM_SAMPLES)
  ) u_unit (
    .clk    (clk),
    .ctrl   (uctrl),
    .data_a (unit_in_a),
    .data_b (unit_in_b),
    .quo_a  (avg_a),
    .quo_b  (avg_b)
  );

  assign up_diff = POS_FULL - {1'b0, avg_a};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_CHECK;
      S_CHECK: state_nxt = ok ? S_WRITE : S_FIN;
      S_WRITE: state_nxt = S_SUM;
      S_SUM:   if (rd_cnt_r == LAST_SLOT) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_DIV;
      S_DIV:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hyst_r      <= HYST_RESET;
      slot_r      <= '0;
      full_r      <= 1'b0;
      rd_cnt_r    <= '0;
      rd_pend_r   <= 1'b0;
      prev_a_r    <= '0;
      prev_b_r    <= '0;
      angle_r     <= '0;
      dir_r       <= DIR_CW;
      ok_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= (state_r == S_SUM);
      if (cfg_valid) begin
        hyst_r <= cfg_data;
      end
      if (state_r == S_CHECK) begin
        ok_r <= ok;
      end
      if (state_r == S_WRITE) begin
        rd_cnt_r <= '0;
        if (slot_r == LAST_SLOT) begin
          slot_r <= '0;
          full_r <= 1'b1;
        end else begin
          slot_r <= slot_r + 1'b1;
        end
      end
      if (state_r == S_SUM) begin
        if (rd_cnt_r != LAST_SLOT) begin
          rd_cnt_r <= rd_cnt_r + 1'b1;
        end
      end
      if (state_r == S_UPD) begin
        if (avg_b >= POS_HALF) begin
          angle_r <= up_diff[VAL_W:1];
          if (avg_a < prev_a_r) begin
            dir_r <= DIR_CW;
          end else if (avg_a > prev_a_r) begin
            dir_r <= DIR_CCW;
          end
        end else begin
          angle_r <= (avg_a >> 1) + POS_HALF;
          if (avg_a > prev_a_r) begin
            dir_r <= DIR_CW;
          end else if (avg_a < prev_a_r) begin
            dir_r <= DIR_CCW;
          end
        end
        prev_a_r <= avg_a;
        prev_b_r <= avg_b;
      end
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      a_r <= in_tdata[VAL_W-1:0];
      b_r <= in_tdata[2*VAL_W-1:VAL_W];
    end
    rd_mask_r <= full_r || (rd_cnt_r < slot_r);
    if (state_r == S_FIN && out_free) begin
      out_pos_r <= angle_r;
      out_dir_r <= dir_r;
      out_acc_r <= ok_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_dir_r, out_pos_r};
  assign out_tuser  = out_acc_r;

`ifndef SYNTHESIS
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result word raised outside the finish state");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= LAST_SLOT)
    else $error("ring write pointer beyond the ring length");

  a_div_one: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |=> state_r == S_UPD)
    else $error("division step lasted more than one cycle");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while a word is still in work");
`endif

endmodule

/* hw/rtl/epd_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module epd_ram #(
  parameter int WIDTH  = 20,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/epd_unit.sv */
// ----------------------------------------------------------------------------
// Endless potentiometer decoder arithmetic unit
// Two accumulator lanes that first sum the ring entries, then divide each sum
// by the ring length with one multiplication by a fixed reciprocal.
// ----------------------------------------------------------------------------
module epd_unit
  import epd_pkg::*;
#(
  parameter int NUM_SAMPLES = DEF_NUM_SAMPLES
) (
  input  logic             clk,
  input  unit_ctrl_t       ctrl,
  input  logic [VAL_W-1:0] data_a,
  input  logic [VAL_W-1:0] data_b,
  output logic [VAL_W-1:0] quo_a,
  output logic [VAL_W-1:0] quo_b
);

  localparam int SUM_W  = VAL_W + $clog2(NUM_SAMPLES + 1);
  localparam int RCP_W  = DIV_SHIFT + 1;
  localparam int PROD_W = SUM_W + RCP_W;
  // Rounded-up reciprocal; its error is small enough that the truncated
  // product equals the truncating quotient for every reachable sum.
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((1 << DIV_SHIFT) + NUM_SAMPLES - 1) / NUM_SAMPLES);

  logic [SUM_W-1:0]  acc_a_r, acc_a_nxt;
  logic [SUM_W-1:0]  acc_b_r, acc_b_nxt;
  logic [VAL_W-1:0]  quo_a_r, quo_a_nxt;
  logic [VAL_W-1:0]  quo_b_r, quo_b_nxt;
  logic [PROD_W-1:0] prod_a, prod_b;

  assign prod_a = PROD_W'(acc_a_r) * PROD_W'(RECIP);
  assign prod_b = PROD_W'(acc_b_r) * PROD_W'(RECIP);

  always_comb begin
    acc_a_nxt = acc_a_r;
    acc_b_nxt = acc_b_r;
    quo_a_nxt = quo_a_r;
    quo_b_nxt = quo_b_r;
    case (ctrl.op)
      UOP_CLR: begin
        acc_a_nxt = '0;
        acc_b_nxt = '0;
        quo_a_nxt = '0;
        quo_b_nxt = '0;
      end
      UOP_ACC: begin
        acc_a_nxt = acc_a_r + SUM_W'(data_a);
        acc_b_nxt = acc_b_r + SUM_W'(data_b);
      end
      UOP_DIV: begin
        quo_a_nxt = prod_a[DIV_SHIFT +: VAL_W];
        quo_b_nxt = prod_b[DIV_SHIFT +: VAL_W];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    acc_a_r <= acc_a_nxt;
    acc_b_r <= acc_b_nxt;
    quo_a_r <= quo_a_nxt;
    quo_b_r <= quo_b_nxt;
  end

  assign quo_a = quo_a_r;
  assign quo_b = quo_b_r;

endmodule

/* test/tb_endless_pot_position_decoder_core.sv */
// ----------------------------------------------------------------------------
// Endless potentiometer decoder testbench
// Streams wiper pairs into the decoder core and checks each position,
// direction and accepted flag against an in-bench model of the hysteresis
// filter, the two averaging rings and the branch selection.
// ----------------------------------------------------------------------------
module tb_endless_pot_position_decoder_core
  import epd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING_LEN         = DEF_NUM_SAMPLES;
  localparam int CYCLE_LIMIT      = 300000;
  localparam int LONG_HOLD_AT     = 200;
  localparam int LONG_HOLD_CYCLES = 250;
  localparam int DRAIN_CYCLES     = 40;

  typedef struct packed {
    logic [VAL_W-1:0] position;
    logic             direction;
    logic             accepted;
  } pot_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [9:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;

  endless_pot_position_decoder_core #(
    .NUM_SAMPLES(RING_LEN)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Decoder model state.
  logic [VAL_W-1:0] hyst_model;
  logic [VAL_W-1:0] wiper_a_ring [RING_LEN];
  logic [VAL_W-1:0] wiper_b_ring [RING_LEN];
  int               slot_model;
  logic [VAL_W-1:0] avg_a_held;
  logic [VAL_W-1:0] avg_b_held;
  logic [VAL_W-1:0] angle_model;
  logic             dir_model;

  logic [23:0] pending_pairs [$];
  pot_result_t expected_results [$];

  int  words_sent = 0;
  int  error_count = 0;
  int  pairs_passed = 0;
  int  pairs_held = 0;
  int  settings_used = 1;
  int  cycle_count = 0;
  int  pot_phase = 0;
  logic quiet = 1'b0;

  int  tx_gap_left = 0;
  int  rx_gap_left = 0;
  int  long_hold_left = 0;
  logic long_hold_done = 1'b0;

  function automatic int abs_delta(int x, int y);
    return (x >= y) ? x - y : y - x;
  endfunction

  // Applies one pair to the model and returns the result the core should give.
  function automatic pot_result_t decode_reading(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    int sum_a;
    int sum_b;
    int avg_a;
    int avg_b;
    logic pass;
    pot_result_t r;
    sum_a = 0;
    sum_b = 0;
    pass = (abs_delta(a, avg_a_held) >= hyst_model) &&
           (abs_delta(b, avg_b_held) >= hyst_model);
    if (pass) begin
      wiper_a_ring[slot_model] = a;
      wiper_b_ring[slot_model] = b;
      slot_model = (slot_model + 1) % RING_LEN;
      for (int i = 0; i < RING_LEN; i++) begin
        sum_a += wiper_a_ring[i];
        sum_b += wiper_b_ring[i];
      end
      avg_a = sum_a / RING_LEN;
      avg_b = sum_b / RING_LEN;
      if (avg_b >= POS_HALF) begin
        angle_model = VAL_W'((POS_FULL - avg_a) / 2);
        if (avg_a < avg_a_held) dir_model = DIR_CW;
        else if (avg_a > avg_a_held) dir_model = DIR_CCW;
      end else begin
        angle_model = VAL_W'(avg_a / 2 + POS_HALF);
        if (avg_a > avg_a_held) dir_model = DIR_CW;
        else if (avg_a < avg_a_held) dir_model = DIR_CCW;
      end
      avg_a_held = VAL_W'(avg_a);
      avg_b_held = VAL_W'(avg_b);
    end
    r.position  = angle_model;
    r.direction = dir_model;
    r.accepted  = pass;
    return r;
  endfunction

  // Wiper voltage of an ideal endless pot: a triangle over one turn.
  function automatic int tri_wave(int ph);
    int v;
    v = ph & 1023;
    return (v < 512) ? 2 * v : 2 * (1023 - v) + 1;
  endfunction

  function automatic int jitter(int v, int amt);
    int r;
    r = v + $urandom_range(0, 2 * amt) - amt;
    if (r < 0) r = 0;
    if (r > 1023) r = 1023;
    return r;
  endfunction

  function automatic int avg_guess_a();
    return tri_wave(pot_phase);
  endfunction

  function automatic int avg_guess_b();
    return tri_wave(pot_phase + 256);
  endfunction

  task automatic queue_pair(int a, int b);
    logic [9:0] wa;
    logic [9:0] wb;
    wa = a[9:0];
    wb = b[9:0];
    pending_pairs.push_back({4'b0000, wb, wa});
  endtask

  // A stretch of knob motion with occasional reversals and a little ADC noise.
  task automatic queue_rotation(int steps, int max_step);
    int dir;
    dir = $urandom_range(0, 1) ? 1 : -1;
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(0, 7) == 0) dir = -dir;
      pot_phase = (pot_phase + dir * $urandom_range(0, max_step)) & 1023;
      queue_pair(jitter(tri_wave(pot_phase), 2), jitter(tri_wave(pot_phase + 256), 2));
    end
  endtask

  // Mostly knob motion; the rest is jitter below the threshold and raw noise.
  task automatic queue_random_phase(int count, int hyst);
    int n;
    int pick;
    int len;
    n = 0;
    while (n < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        len = $urandom_range(8, 24);
        queue_rotation(len, hyst / 2 + 8);
        n += len;
      end else if (pick < 85) begin
        queue_pair(jitter(avg_guess_a(), hyst / 2), jitter(avg_guess_b(), hyst / 2));
        n++;
      end else begin
        queue_pair($urandom_range(0, 1023), $urandom_range(0, 1023));
        n++;
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_pairs.size() != 0 || expected_results.size() != 0 || in_tvalid);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_hysteresis(logic [9:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid  <= 1'b0;
    hyst_model = value;
    settings_used++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: presents queued words, with random idle bursts between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      tx_gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(decode_reading(in_tdata[9:0], in_tdata[19:10]));
        words_sent <= words_sent + 1;
      end
      if (in_tvalid && !in_tready) begin
        // Hold the word until the core takes it.
      end else if (tx_gap_left > 0) begin
        tx_gap_left <= tx_gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        tx_gap_left <= $urandom_range(0, 8);
        in_tvalid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= pending_pairs.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off so the core backs up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (long_hold_left > 0) begin
      long_hold_left <= long_hold_left - 1;
      out_tready <= 1'b0;
    end else if (!long_hold_done && words_sent >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      long_hold_left <= LONG_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (rx_gap_left > 0) begin
      rx_gap_left <= rx_gap_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      rx_gap_left <= $urandom_range(0, 8);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: each result word is checked against the oldest prediction.
  always @(posedge clk) begin
    pot_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result word 0x%04h/%0b arrived with no prediction pending", out_tdata, out_tuser);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tdata[9:0] !== exp_r.position) begin
          $error("position: expected %0d, got %0d", exp_r.position, out_tdata[9:0]);
          error_count++;
        end
        if (out_tdata[10] !== exp_r.direction) begin
          $error("direction: expected %0b, got %0b", exp_r.direction, out_tdata[10]);
          error_count++;
        end
        if (out_tuser !== exp_r.accepted) begin
          $error("accepted: expected %0b, got %0b", exp_r.accepted, out_tuser);
          error_count++;
        end
        if (out_tdata[15:11] !== 5'd0) begin
          $error("padding: expected 0, got 0x%0h", out_tdata[15:11]);
          error_count++;
        end
        if (exp_r.accepted) pairs_passed++;
        else pairs_held++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $error("timeout with %0d results still expected", expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int settings [6];
    hyst_model  = HYST_RESET;
    for (int i = 0; i < RING_LEN; i++) begin
      wiper_a_ring[i] = '0;
      wiper_b_ring[i] = '0;
    end
    slot_model  = 0;
    avg_a_held  = '0;
    avg_b_held  = '0;
    angle_model = '0;
    dir_model   = DIR_CW;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset threshold: a zero pair is held off, full scale rises through
    // the lower branch, then the B average crosses into the upper branch.
    @(negedge clk);
    queue_pair(0, 0);
    for (int i = 0; i < 5; i++) queue_pair(1023, 1023);
    queue_pair(0, 1023);
    queue_pair(1023, 0);
    queue_pair(0, 0);
    queue_pair(1, 1);
    queue_pair(512, 511);
    queue_pair(511, 512);
    wait_idle();

    // Zero threshold: every pair passes, and a steady ring holds the direction.
    write_hysteresis(10'd0);
    @(negedge clk);
    for (int i = 0; i < 9; i++) queue_pair(0, 0);
    queue_pair(1023, 0);
    wait_idle();

    // Full-scale threshold: almost nothing gets through.
    write_hysteresis(10'd1023);
    @(negedge clk);
    queue_pair(1023, 1023);
    queue_pair(0, 0);
    queue_pair(1023, 0);
    queue_pair(0, 1023);
    queue_pair(1023, 1023);
    wait_idle();

    settings = '{3, 1, 0, 12, 40, $urandom_range(2, 60)};
    foreach (settings[k]) begin
      write_hysteresis(settings[k][9:0]);
      @(negedge clk);
      queue_random_phase(95, settings[k]);
      wait_idle();
    end

    // Closing stretch at full rate on both sides.
    write_hysteresis(10'd5);
    quiet <= 1'b1;
    @(negedge clk);
    queue_random_phase(60, 5);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d wiper pairs under %0d threshold settings: %0d passed, %0d held off.",
             words_sent, settings_used, pairs_passed, pairs_held);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/epd_pkg.sv
hw/rtl/epd_ram.sv
hw/rtl/epd_unit.sv
hw/rtl/endless_pot_position_decoder_core.sv
test/tb_endless_pot_position_decoder_core.sv
